[rtl/cpci_pkg.sv]
// ----------------------------------------------------------------------------
// cpci_pkg
// Shared widths, request and pipeline types and the saturation helper for the
// two-disc collision impulse pipeline.
// ----------------------------------------------------------------------------
package cpci_pkg;

  localparam int PW    = 16;          // position / velocity width
  localparam int RW    = 12;          // radius width
  localparam int DXW   = PW + 1;      // centre / velocity difference
  localparam int MAGW  = RW + 1;      // |dx| while discs overlap
  localparam int DISTW = 2 * MAGW;    // |d|^2 while discs overlap
  localparam int DOTW  = 31;          // -dot while discs overlap
  localparam int SCW   = DOTW + 9;    // (256 + e) * -dot
  localparam int NW    = MAGW + SCW + 1; // rounded numerator
  localparam int DW    = DISTW + 8;   // 256 * |d|^2
  localparam int QW    = 19;          // impulse magnitude bits
  localparam int SW    = QW + 2;      // velocity minus impulse

  localparam logic [7:0] RESTITUTION_RST = 8'd51;

  typedef struct packed {
    logic signed [PW-1:0] p1x;
    logic signed [PW-1:0] p1y;
    logic signed [PW-1:0] v1x;
    logic signed [PW-1:0] v1y;
    logic        [RW-1:0] r1;
    logic signed [PW-1:0] p2x;
    logic signed [PW-1:0] p2y;
    logic signed [PW-1:0] v2x;
    logic signed [PW-1:0] v2y;
    logic        [RW-1:0] r2;
  } cpci_req_t;

  typedef struct packed {
    logic                 vld;
    logic                 applied;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [PW-1:0] v1x;
    logic signed [PW-1:0] v1y;
    logic signed [PW-1:0] v2x;
    logic signed [PW-1:0] v2y;
  } cpci_tag_t;

  typedef struct packed {
    cpci_tag_t     tag;
    logic [NW-1:0] rem_x;
    logic [NW-1:0] rem_y;
    logic [DW-1:0] den;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
  } cpci_div_t;

  function automatic logic signed [PW-1:0] sat16(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'(32767);
    lo = -SW'(32768);
    if (v > hi) begin
      return 16'sh7fff;
    end else if (v < lo) begin
      return 16'sh8000;
    end else begin
      return v[PW-1:0];
    end
  endfunction

endpackage

[rtl/cpci_front.sv]
// ----------------------------------------------------------------------------
// cpci_front
// Geometry front end: differences, squared distance, overlap and approach
// test, impulse numerator and divisor for the divider chain.
// ----------------------------------------------------------------------------
module cpci_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               req_vld,
  input  cpci_pkg::cpci_req_t req,
  input  logic [7:0]         restitution,
  output cpci_pkg::cpci_div_t div_out
);
  import cpci_pkg::*;

  // stage 1: differences
  cpci_tag_t              s1_tag_r;
  logic signed [DXW-1:0]  s1_dx_r, s1_dy_r, s1_dvx_r, s1_dvy_r;
  logic [MAGW-1:0]        s1_rsum_r;
  // stage 2: products
  cpci_tag_t              s2_tag_r;
  cpci_tag_t              s2_tag_nxt;
  logic signed [2*DXW-1:0] s2_dxx_r, s2_dyy_r, s2_pdx_r, s2_pdy_r;
  logic [DISTW-1:0]       s2_rr_r;
  logic [MAGW-1:0]        s2_adx_r, s2_ady_r;
  // stage 3: sums and tests
  cpci_tag_t              s3_tag_r;
  cpci_tag_t              s3_tag_nxt;
  logic [DISTW-1:0]       s3_dist_r;
  logic [DOTW-1:0]        s3_negdot_r;
  logic [MAGW-1:0]        s3_adx_r, s3_ady_r;
  // stage 4: restitution scaling
  cpci_tag_t              s4_tag_r;
  logic [SCW-1:0]         s4_scal_r;
  logic [DISTW-1:0]       s4_dist_r;
  logic [MAGW-1:0]        s4_adx_r, s4_ady_r;
  // stage 5: numerators
  cpci_tag_t              s5_tag_r;
  logic [NW-1:0]          s5_num_x_r, s5_num_y_r;
  logic [DISTW-1:0]       s5_dist_r;
  // stage 6: rounding offset
  cpci_div_t              s6_r;

  cpci_tag_t              tag_in;
  logic [2*DXW:0]         dist_full;
  logic signed [2*DXW:0]  dot_full;
  logic signed [2*DXW:0]  negdot_full;
  logic                   overlap;
  logic                   closing;
  logic signed [DXW-1:0]  adx_full, ady_full;

  always_comb begin
    tag_in.vld     = req_vld;
    tag_in.applied = 1'b0;
    tag_in.neg_x   = 1'b0;
    tag_in.neg_y   = 1'b0;
    tag_in.v1x     = req.v1x;
    tag_in.v1y     = req.v1y;
    tag_in.v2x     = req.v2x;
    tag_in.v2y     = req.v2y;
    adx_full    = s1_dx_r[DXW-1] ? -s1_dx_r : s1_dx_r;
    ady_full    = s1_dy_r[DXW-1] ? -s1_dy_r : s1_dy_r;
    dist_full   = {1'b0, s2_dxx_r} + {1'b0, s2_dyy_r};
    dot_full    = {s2_pdx_r[2*DXW-1], s2_pdx_r} + {s2_pdy_r[2*DXW-1], s2_pdy_r};
    negdot_full = -dot_full;
    overlap     = (dist_full != '0) && (dist_full < (2*DXW+1)'(s2_rr_r));
    closing     = dot_full[2*DXW] || (dot_full == '0);

    s2_tag_nxt       = s1_tag_r;
    s2_tag_nxt.neg_x = s1_dx_r[DXW-1];
    s2_tag_nxt.neg_y = s1_dy_r[DXW-1];

    s3_tag_nxt         = s2_tag_r;
    s3_tag_nxt.applied = overlap && closing;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.vld <= 1'b0;
      s2_tag_r.vld <= 1'b0;
      s3_tag_r.vld <= 1'b0;
      s4_tag_r.vld <= 1'b0;
      s5_tag_r.vld <= 1'b0;
      s6_r.tag.vld <= 1'b0;
    end else if (en) begin
      s1_tag_r  <= tag_in;
      s1_dx_r   <= DXW'(req.p2x) - DXW'(req.p1x);
      s1_dy_r   <= DXW'(req.p2y) - DXW'(req.p1y);
      s1_dvx_r  <= DXW'(req.v2x) - DXW'(req.v1x);
      s1_dvy_r  <= DXW'(req.v2y) - DXW'(req.v1y);
      s1_rsum_r <= MAGW'(req.r1) + MAGW'(req.r2);

      s2_tag_r  <= s2_tag_nxt;
      s2_dxx_r  <= (2*DXW)'(s1_dx_r * s1_dx_r);
      s2_dyy_r  <= (2*DXW)'(s1_dy_r * s1_dy_r);
      s2_pdx_r  <= (2*DXW)'(s1_dvx_r * s1_dx_r);
      s2_pdy_r  <= (2*DXW)'(s1_dvy_r * s1_dy_r);
      s2_rr_r   <= DISTW'(s1_rsum_r * s1_rsum_r);
      s2_adx_r  <= adx_full[MAGW-1:0];
      s2_ady_r  <= ady_full[MAGW-1:0];

      // values are only meaningful on overlap, where they fit the narrow widths
      s3_tag_r         <= s3_tag_nxt;
      s3_dist_r        <= dist_full[DISTW-1:0];
      s3_negdot_r      <= negdot_full[DOTW-1:0];
      s3_adx_r         <= s2_adx_r;
      s3_ady_r         <= s2_ady_r;

      s4_tag_r  <= s3_tag_r;
      s4_scal_r <= SCW'({1'b1, restitution}) * SCW'(s3_negdot_r);
      s4_dist_r <= s3_dist_r;
      s4_adx_r  <= s3_adx_r;
      s4_ady_r  <= s3_ady_r;

      s5_tag_r   <= s4_tag_r;
      s5_num_x_r <= NW'(s4_adx_r) * NW'(s4_scal_r);
      s5_num_y_r <= NW'(s4_ady_r) * NW'(s4_scal_r);
      s5_dist_r  <= s4_dist_r;

      // add half the divisor for round-half-away-from-zero
      s6_r.tag   <= s5_tag_r;
      s6_r.rem_x <= s5_num_x_r + NW'({s5_dist_r, 7'b0});
      s6_r.rem_y <= s5_num_y_r + NW'({s5_dist_r, 7'b0});
      s6_r.den   <= {s5_dist_r, 8'b0};
      s6_r.q_x   <= '0;
      s6_r.q_y   <= '0;
    end
  end

  assign div_out = s6_r;

endmodule

[rtl/cpci_div_cell.sv]
// ----------------------------------------------------------------------------
// cpci_div_cell
// One restoring-division cell: resolves one quotient bit for both impulse
// components and hands the remainders on to the next cell.
// ----------------------------------------------------------------------------
module cpci_div_cell #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cpci_pkg::cpci_div_t d_in,
  output cpci_pkg::cpci_div_t d_out
);
  import cpci_pkg::*;

  cpci_div_t     cell_r;
  cpci_div_t     cell_nxt;
  logic [NW-1:0] trial;
  logic          ge_x, ge_y;

  always_comb begin
    trial    = NW'(d_in.den) << BIT;
    ge_x     = d_in.rem_x >= trial;
    ge_y     = d_in.rem_y >= trial;
    cell_nxt = d_in;
    if (ge_x) begin
      cell_nxt.rem_x = d_in.rem_x - trial;
    end
    if (ge_y) begin
      cell_nxt.rem_y = d_in.rem_y - trial;
    end
    cell_nxt.q_x[BIT] = ge_x;
    cell_nxt.q_y[BIT] = ge_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.tag.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

[rtl/circle_pair_collision_impulse.sv]
// ----------------------------------------------------------------------------
// circle_pair_collision_impulse
// Two-disc collision impulse response: overlap and approach test, impulse
// along the centre difference, saturated new velocities.
// ----------------------------------------------------------------------------
// One disc pair is taken every cycle unless the pipeline is stalled. Each
// passes 26 register stages: six of geometry and scaling, one per quotient
// bit in a row of 19 divider cells, and one output register that applies the
// impulse and saturates. A stall on the result side holds the whole pipeline,
// and in_stall follows it. The restitution register is sampled by each
// request as it passes the scaling stage, so write it only while the pipeline
// is empty.
module circle_pair_collision_impulse (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] in_first_pos_x,
  input  logic signed [15:0] in_first_pos_y,
  input  logic signed [15:0] in_first_vel_x,
  input  logic signed [15:0] in_first_vel_y,
  input  logic        [11:0] in_first_radius,
  input  logic signed [15:0] in_second_pos_x,
  input  logic signed [15:0] in_second_pos_y,
  input  logic signed [15:0] in_second_vel_x,
  input  logic signed [15:0] in_second_vel_y,
  input  logic        [11:0] in_second_radius,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_new_first_vel_x,
  output logic signed [15:0] out_new_first_vel_y,
  output logic signed [15:0] out_new_second_vel_x,
  output logic signed [15:0] out_new_second_vel_y,
  output logic        out_impulse_applied
);
  import cpci_pkg::*;

  logic        en;
  logic [7:0]  restitution_r;
  cpci_req_t   req;
  cpci_div_t   chain [QW+1];

  logic                 out_vld_r;
  logic signed [PW-1:0] v1x_r, v1y_r, v2x_r, v2y_r;
  logic                 applied_r;

  cpci_div_t            last;
  logic signed [SW-1:0] jx, jy;

  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restitution_r <= RESTITUTION_RST;
    end else if (cfg_wr_en) begin
      restitution_r <= cfg_wr_data;
    end
  end

  always_comb begin
    req.p1x = in_first_pos_x;
    req.p1y = in_first_pos_y;
    req.v1x = in_first_vel_x;
    req.v1y = in_first_vel_y;
    req.r1  = in_first_radius;
    req.p2x = in_second_pos_x;
    req.p2y = in_second_pos_y;
    req.v2x = in_second_vel_x;
    req.v2y = in_second_vel_y;
    req.r2  = in_second_radius;
  end

  cpci_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .req_vld     (in_valid),
    .req         (req),
    .restitution (restitution_r),
    .div_out     (chain[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_cell
    cpci_div_cell #(
      .BIT (QW - 1 - k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (chain[k]),
      .d_out (chain[k+1])
    );
  end

  always_comb begin
    last = chain[QW];
    jx   = last.tag.neg_x ? -SW'(last.q_x) : SW'(last.q_x);
    jy   = last.tag.neg_y ? -SW'(last.q_y) : SW'(last.q_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= last.tag.vld;
      applied_r <= last.tag.applied;
      if (last.tag.applied) begin
        v1x_r <= sat16(SW'(last.tag.v1x) - jx);
        v1y_r <= sat16(SW'(last.tag.v1y) - jy);
        v2x_r <= sat16(SW'(last.tag.v2x) + jx);
        v2y_r <= sat16(SW'(last.tag.v2y) + jy);
      end else begin
        v1x_r <= last.tag.v1x;
        v1y_r <= last.tag.v1y;
        v2x_r <= last.tag.v2x;
        v2y_r <= last.tag.v2y;
      end
    end
  end

  assign out_valid            = out_vld_r;
  assign out_new_first_vel_x  = v1x_r;
  assign out_new_first_vel_y  = v1y_r;
  assign out_new_second_vel_x = v2x_r;
  assign out_new_second_vel_y = v2y_r;
  assign out_impulse_applied  = applied_r;

endmodule
